// ----- sv/pdpe_pkg.sv -----
// ----------------------------------------------------------------------------
// pdpe_pkg
// shared types and constants of the predictive delta position encoder
// ----------------------------------------------------------------------------
package pdpe_pkg;

  localparam int HDR_LEN  = 10;
  localparam int PKT_MAX  = 18;
  localparam int LEN_W    = 5;

  localparam logic [1:0] MODE_KEY  = 2'd0;
  localparam logic [1:0] MODE_D16  = 2'd1;
  localparam logic [1:0] MODE_D8   = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [7:0] FLAG_PRED = 8'h04;
  localparam logic [7:0] FLAG_KEY  = 8'h08;

  localparam logic [1:0] REG_SCALE   = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_CAP     = 2'd2;

  // one built packet, bytes in emit order
  typedef struct packed {
    logic [PKT_MAX-1:0][7:0] bytes;
    logic [LEN_W-1:0]        len;
    logic                    rej;
  } pkt_t;

  // configuration seen by the front part
  typedef struct packed {
    logic [9:0]  scale;
    logic [7:0]  version;
    logic [15:0] cap;
  } cfg_t;

endpackage

// ----- sv/pdpe_front.sv -----
// ----------------------------------------------------------------------------
// pdpe_front
// seven-stage pipeline that classifies a snapshot and builds its packet
// ----------------------------------------------------------------------------
module pdpe_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pdpe_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [31:0]    pos_x,
  input  logic [31:0]    pos_y,
  input  logic [31:0]    prev_x,
  input  logic [31:0]    prev_y,
  input  logic [31:0]    prev_vel_x,
  input  logic [31:0]    prev_vel_y,
  input  logic [15:0]    snapshot_number,
  input  logic [15:0]    acked_input_number,
  input  logic [31:0]    time_stamp,
  input  logic           force_key,
  input  logic [15:0]    frame_interval,
  output logic           pkt_valid,
  input  logic           pkt_ready,
  output pdpe_pkg::pkt_t pkt
);
  import pdpe_pkg::*;

  localparam logic [63:0] SLOW_LIM = ((64'd1 << (2*FRAC_BITS)) + 64'd99) / 64'd100;
  localparam logic [47:0] THR_SLOW = 48'd20 << FRAC_BITS;
  localparam logic [47:0] THR_FAST = 48'd5 << FRAC_BITS;
  localparam logic [47:0] LIM8     = 48'd127 << FRAC_BITS;
  localparam logic [47:0] LIM16    = 48'd32767 << FRAC_BITS;
  localparam logic [46:0] HALF_Q   = 47'd1 << (FRAC_BITS - 1);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [15:0] snap;
    logic [15:0] ack;
    logic [31:0] ts;
    logic        key;
  } hdr_t;

  logic [7:1] v_r;
  logic       en;

  assign en        = !v_r[7] || pkt_ready;
  assign in_ready  = en;
  assign pkt_valid = v_r[7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:1], in_valid};
    end
  end

  // stage 1: interval factor, snapshot mod 30 quotient, plain deltas
  hdr_t               h1_r;
  logic [19:0]        q1_r;
  logic [11:0]        snq1_r;
  logic signed [32:0] dx1_r, dy1_r;
  logic [31:0]        vx1_r, vy1_r;
  logic [29:0]        n1;
  logic [60:0]        nm1;
  logic [32:0]        sp1;

  always_comb begin
    n1  = 30'({14'b0, frame_interval} * 30'd12800) + 30'd416;
    nm1 = {31'b0, n1} * 61'd1319941931;
    sp1 = {17'b0, snapshot_number} * 33'd69906;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1_r   <= '{x: pos_x, y: pos_y, snap: snapshot_number, ack: acked_input_number,
                  ts: time_stamp, key: force_key};
      q1_r   <= nm1[59:40];
      snq1_r <= sp1[32:21];
      dx1_r  <= $signed({pos_x[31], pos_x}) - $signed({prev_x[31], prev_x});
      dy1_r  <= $signed({pos_y[31], pos_y}) - $signed({prev_y[31], prev_y});
      vx1_r  <= prev_vel_x;
      vy1_r  <= prev_vel_y;
    end
  end

  // stage 2: clamp factor, keyframe rule, speed squares
  hdr_t               h2_r;
  logic [17:0]        f2_r;
  logic signed [32:0] dx2_r, dy2_r;
  logic [31:0]        vx2_r, vy2_r;
  logic [63:0]        sqx2_r, sqy2_r;
  logic [31:0]        mvx2, mvy2;
  logic [16:0]        rem2;

  always_comb begin
    mvx2 = vx1_r[31] ? 32'(-vx1_r) : vx1_r;
    mvy2 = vy1_r[31] ? 32'(-vy1_r) : vy1_r;
    rem2 = {1'b0, h1_r.snap} - 17'({5'b0, snq1_r} * 17'd30);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h2_r     <= '{x: h1_r.x, y: h1_r.y, snap: h1_r.snap, ack: h1_r.ack, ts: h1_r.ts,
                    key: h1_r.key || (rem2 == 17'd0)};
      if (q1_r < 20'd32768)       f2_r <= 18'd32768;
      else if (q1_r > 20'd131072) f2_r <= 18'd131072;
      else                        f2_r <= q1_r[17:0];
      dx2_r  <= dx1_r;
      dy2_r  <= dy1_r;
      vx2_r  <= vx1_r;
      vy2_r  <= vy1_r;
      sqx2_r <= {32'b0, mvx2} * {32'b0, mvx2};
      sqy2_r <= {32'b0, mvy2} * {32'b0, mvy2};
    end
  end

  // stage 3: velocity times factor, slow test
  hdr_t               h3_r;
  logic signed [32:0] dx3_r, dy3_r;
  logic signed [50:0] pvx3_r, pvy3_r;
  logic               slow3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      h3_r    <= h2_r;
      dx3_r   <= dx2_r;
      dy3_r   <= dy2_r;
      pvx3_r  <= 51'($signed(vx2_r) * $signed({1'b0, f2_r}));
      pvy3_r  <= 51'($signed(vy2_r) * $signed({1'b0, f2_r}));
      slow3_r <= ({1'b0, sqx2_r} + {1'b0, sqy2_r}) < {1'b0, SLOW_LIM};
    end
  end

  // stage 4: round prediction, predicted deltas
  hdr_t               h4_r;
  logic signed [35:0] dx4_r, dy4_r, px4_r, py4_r;
  logic               slow4_r;
  logic [50:0]        mpx4, mpy4;
  logic [34:0]        rx4, ry4;

  always_comb begin
    mpx4 = pvx3_r[50] ? 51'(-pvx3_r) : 51'(pvx3_r);
    mpy4 = pvy3_r[50] ? 51'(-pvy3_r) : 51'(pvy3_r);
    rx4  = 35'((mpx4 + 51'd32768) >> 16);
    ry4  = 35'((mpy4 + 51'd32768) >> 16);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h4_r    <= h3_r;
      slow4_r <= slow3_r;
      dx4_r   <= 36'(dx3_r);
      dy4_r   <= 36'(dy3_r);
      px4_r   <= 36'(dx3_r) - (pvx3_r[50] ? -$signed({1'b0, rx4}) : $signed({1'b0, rx4}));
      py4_r   <= 36'(dy3_r) - (pvy3_r[50] ? -$signed({1'b0, ry4}) : $signed({1'b0, ry4}));
    end
  end

  // stage 5: keep the delta with the smaller sum
  hdr_t               h5_r;
  logic signed [35:0] dx5_r, dy5_r;
  logic [35:0]        ax5_r, ay5_r;
  logic               pred5_r, slow5_r;
  logic [35:0]        adx5, ady5, apx5, apy5;
  logic               pick5;

  always_comb begin
    adx5  = dx4_r[35] ? 36'(-dx4_r) : 36'(dx4_r);
    ady5  = dy4_r[35] ? 36'(-dy4_r) : 36'(dy4_r);
    apx5  = px4_r[35] ? 36'(-px4_r) : 36'(px4_r);
    apy5  = py4_r[35] ? 36'(-py4_r) : 36'(py4_r);
    pick5 = ({1'b0, apx5} + {1'b0, apy5}) < ({1'b0, adx5} + {1'b0, ady5});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h5_r    <= h4_r;
      slow5_r <= slow4_r;
      pred5_r <= pick5;
      dx5_r   <= pick5 ? px4_r : dx4_r;
      dy5_r   <= pick5 ? py4_r : dy4_r;
      ax5_r   <= pick5 ? apx5 : adx5;
      ay5_r   <= pick5 ? apy5 : ady5;
    end
  end

  // stage 6: mode, scaled deltas, leading one of positions
  hdr_t               h6_r;
  logic [1:0]         mode6_r;
  logic               pred6_r;
  logic signed [46:0] sx6_r, sy6_r;
  logic [31:0]        mx6_r, my6_r;
  logic [4:0]         p6x_r, p6y_r;
  logic [47:0]        tx6, ty6, thr6;
  logic [1:0]         mode6;
  logic [31:0]        mx6, my6;
  logic [4:0]         px6, py6;

  always_comb begin
    tx6  = 48'({12'b0, ax5_r} * 48'd10);
    ty6  = 48'({12'b0, ay5_r} * 48'd10);
    thr6 = slow5_r ? THR_SLOW : THR_FAST;
    if (h5_r.key)                                  mode6 = MODE_KEY;
    else if (tx6 * 48'd100 < thr6 && ty6 * 48'd100 < thr6) mode6 = MODE_NONE;
    else if (tx6 * 48'd10 < LIM8 && ty6 * 48'd10 < LIM8)   mode6 = MODE_D8;
    else if (tx6 * 48'd10 < LIM16 && ty6 * 48'd10 < LIM16) mode6 = MODE_D16;
    else                                           mode6 = MODE_KEY;
    mx6 = h5_r.x[31] ? 32'(-h5_r.x) : h5_r.x;
    my6 = h5_r.y[31] ? 32'(-h5_r.y) : h5_r.y;
    px6 = '0;
    py6 = '0;
    for (int i = 0; i < 32; i++) begin
      if (mx6[i]) px6 = 5'(i);
      if (my6[i]) py6 = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h6_r    <= h5_r;
      mode6_r <= mode6;
      pred6_r <= pred5_r;
      sx6_r   <= 47'(dx5_r * $signed({1'b0, cfg.scale}));
      sy6_r   <= 47'(dy5_r * $signed({1'b0, cfg.scale}));
      mx6_r   <= mx6;
      my6_r   <= my6;
      p6x_r   <= px6;
      p6y_r   <= py6;
    end
  end

  // stage 7: quantize, float conversion, capacity check, packet assembly
  function automatic logic [15:0] quant(input logic signed [46:0] s, input logic wide);
    logic [46:0] m, q;
    logic [46:0] lim;
    logic [15:0] r;
    m   = s[46] ? 47'(-s) : 47'(s);
    q   = (m + HALF_Q) >> FRAC_BITS;
    lim = wide ? 47'd32767 : 47'd127;
    if (s[46]) r = (q > lim + 47'd1) ? 16'(-(lim + 47'd1)) : 16'(-q);
    else       r = (q > lim) ? lim[15:0] : q[15:0];
    return r;
  endfunction

  function automatic logic [31:0] to_single(input logic sgn, input logic [31:0] m,
                                            input logic [4:0] p);
    logic [4:0]  sh;
    logic [31:0] rem, half, mant;
    logic [31:0] ex;
    sh   = '0;
    rem  = '0;
    half = '0;
    mant = '0;
    if (p <= 5'd23) begin
      mant = m << (5'd23 - p);
    end else begin
      sh   = p - 5'd23;
      rem  = m & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 5'd1);
      mant = m >> sh;
      if (rem > half || (rem == half && mant[0])) mant = mant + 32'd1;
    end
    ex = 32'({27'b0, p} + 32'd126 - 32'(FRAC_BITS));
    return (m == 32'd0) ? 32'd0 : ({sgn, 31'b0} | ((ex << 23) + mant));
  endfunction

  pkt_t        pkt_r;
  pkt_t        pk7;
  logic [15:0] qx7, qy7;
  logic [31:0] fx7, fy7;
  logic [4:0]  plen7;
  logic [7:0]  flags7;

  always_comb begin
    qx7   = quant(sx6_r, mode6_r == MODE_D16);
    qy7   = quant(sy6_r, mode6_r == MODE_D16);
    fx7   = to_single(h6_r.x[31], mx6_r, p6x_r);
    fy7   = to_single(h6_r.y[31], my6_r, p6y_r);
    flags7 = {6'b0, mode6_r} | (pred6_r ? FLAG_PRED : 8'h00) | (h6_r.key ? FLAG_KEY : 8'h00);
    unique case (mode6_r)
      MODE_KEY:  plen7 = 5'd8;
      MODE_D16:  plen7 = 5'd4;
      MODE_D8:   plen7 = 5'd2;
      default:   plen7 = 5'd0;
    endcase
    pk7.bytes     = '0;
    pk7.bytes[0]  = cfg.version;
    pk7.bytes[1]  = flags7;
    pk7.bytes[2]  = h6_r.snap[7:0];
    pk7.bytes[3]  = h6_r.snap[15:8];
    pk7.bytes[4]  = h6_r.ack[7:0];
    pk7.bytes[5]  = h6_r.ack[15:8];
    pk7.bytes[6]  = h6_r.ts[7:0];
    pk7.bytes[7]  = h6_r.ts[15:8];
    pk7.bytes[8]  = h6_r.ts[23:16];
    pk7.bytes[9]  = h6_r.ts[31:24];
    unique case (mode6_r)
      MODE_KEY: begin
        pk7.bytes[10] = fx7[7:0];
        pk7.bytes[11] = fx7[15:8];
        pk7.bytes[12] = fx7[23:16];
        pk7.bytes[13] = fx7[31:24];
        pk7.bytes[14] = fy7[7:0];
        pk7.bytes[15] = fy7[15:8];
        pk7.bytes[16] = fy7[23:16];
        pk7.bytes[17] = fy7[31:24];
      end
      MODE_D16: begin
        pk7.bytes[10] = qx7[7:0];
        pk7.bytes[11] = qx7[15:8];
        pk7.bytes[12] = qy7[7:0];
        pk7.bytes[13] = qy7[15:8];
      end
      MODE_D8: begin
        pk7.bytes[10] = qx7[7:0];
        pk7.bytes[11] = qy7[7:0];
      end
      default: ;
    endcase
    pk7.len = 5'(HDR_LEN) + plen7;
    pk7.rej = 1'b0;
    if (cfg.cap < {11'b0, pk7.len}) begin
      pk7.bytes = '0;
      pk7.len   = 5'd1;
      pk7.rej   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pkt_r <= pk7;
    end
  end

  assign pkt = pkt_r;

endmodule

// ----- sv/pdpe_fifo.sv -----
// ----------------------------------------------------------------------------
// pdpe_fifo
// two-entry packet queue between the front and back parts
// ----------------------------------------------------------------------------
module pdpe_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pdpe_pkg::pkt_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output pdpe_pkg::pkt_t rdata
);
  import pdpe_pkg::*;

  pkt_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

endmodule

// ----- sv/pdpe_back.sv -----
// ----------------------------------------------------------------------------
// pdpe_back
// serializes queued packets one byte per cycle into a register, unless stalled
// ----------------------------------------------------------------------------
module pdpe_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           empty,
  input  pdpe_pkg::pkt_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_last,
  output logic           out_rej
);
  import pdpe_pkg::*;

  logic [LEN_W-1:0] idx_r;
  logic             ov_r, last_r, rej_r;
  logic [7:0]       byte_r;
  logic             load, is_last;

  assign load    = (!ov_r || out_ready) && !empty;
  assign is_last = idx_r == head.len - 5'd1;
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= '0;
    end else begin
      if (load)           ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      if (load) idx_r <= is_last ? '0 : idx_r + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= head.bytes[idx_r];
      last_r <= is_last;
      rej_r  <= head.rej;
    end
  end

  assign out_valid = ov_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;
  assign out_rej   = rej_r;

endmodule

// ----- sv/predictive_delta_position_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// predictive_delta_position_encoder_unit
// dead-reckoning packet builder for 2-D position snapshots
// ----------------------------------------------------------------------------
// usage
//   in_ channel: one snapshot per transaction (positions, previous velocity,
//   header numbers, frame interval); force_key rides on in_tuser
//   out_ channel: one packet byte per transaction, header first, tlast on the
//   final byte; tuser high marks the single byte of a rejected packet
//   cfg_ port: delta scale at 0x0, version byte at 0x4, capacity at 0x8
// packets: a packet of n bytes (1, 10, 12, 14 or 18) holds the byte serializer
//   until its last byte leaves; the seven-stage classify pipeline and a two-deep
//   packet queue keep snapshots flowing while earlier packets drain
// reset: synchronous on rst_n low; clears pipeline, queue and output valid
//   and loads the register defaults (100, 77, 18)
// stall: a held out_tready freezes the byte register, the queue fills, and
//   then in_tready drops until the serializer moves again
// ----------------------------------------------------------------------------
module predictive_delta_position_encoder_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_x, pos_y, prev_x, prev_y, prev_vel_x, prev_vel_y, snapshot_number,
  // acked_input_number, time_stamp, frame_interval
  input  logic [271:0] in_tdata,
  // force_key
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_byte
  output logic [7:0]   out_tdata,
  output logic         out_tlast,
  // rejected
  output logic         out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import pdpe_pkg::*;

  // config registers
  logic [9:0]  scale_r;
  logic [7:0]  version_r;
  logic [15:0] cap_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= 10'd100;
      version_r <= 8'd77;
      cap_r     <= 16'd18;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SCALE:   scale_r   <= cfg_pwdata[9:0];
        REG_VERSION: version_r <= cfg_pwdata[7:0];
        REG_CAP:     cap_r     <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCALE:   cfg_prdata = {22'b0, scale_r};
      REG_VERSION: cfg_prdata = {24'b0, version_r};
      REG_CAP:     cfg_prdata = {16'b0, cap_r};
      default:     cfg_prdata = 32'b0;
    endcase
  end

  cfg_t cfg;
  assign cfg = '{scale: scale_r, version: version_r, cap: cap_r};

  // front: classify and build
  pkt_t fr_pkt, q_head;
  logic fr_valid, q_full, q_empty, q_pop;

  pdpe_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .in_valid           (in_tvalid),
    .in_ready           (in_tready),
    .pos_x              (in_tdata[31:0]),
    .pos_y              (in_tdata[63:32]),
    .prev_x             (in_tdata[95:64]),
    .prev_y             (in_tdata[127:96]),
    .prev_vel_x         (in_tdata[159:128]),
    .prev_vel_y         (in_tdata[191:160]),
    .snapshot_number    (in_tdata[207:192]),
    .acked_input_number (in_tdata[223:208]),
    .time_stamp         (in_tdata[255:224]),
    .force_key          (in_tuser),
    .frame_interval     (in_tdata[271:256]),
    .pkt_valid          (fr_valid),
    .pkt_ready          (!q_full),
    .pkt                (fr_pkt)
  );

  // packet queue
  pdpe_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_valid),
    .wdata (fr_pkt),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_head)
  );

  // back: byte serializer
  pdpe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_rej   (out_tuser)
  );

`ifndef SYNTHESIS
  // a rejected packet is always a single closing byte
  a_rej_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("rejected byte without tlast");

  // the front only stalls when its packet cannot enter the queue
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> fr_valid && q_full)
    else $error("front stalled with room in queue");

  // a pop only happens on the packet's final byte
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_tvalid && out_tlast)
    else $error("queue pop without final byte");
`endif

endmodule
